// File: rtl/rekeys_pkg.sv
// ----------------------------------------------------------------------------
// rekeys_pkg
// Shared types and constants of the rotary encoder and key scanner.
// ----------------------------------------------------------------------------
package rekeys_pkg;

  localparam int unsigned StepW   = 6;
  localparam int unsigned ThreshW = 8;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [StepW-1:0]   MaxStep        = 6'd63;
  localparam logic [StepW-1:0]   StepReset      = 6'd1;
  localparam logic [ThreshW-1:0] ThreshReset    = 8'd10;
  localparam logic [ThreshW-1:0] KeyCountMax    = 8'hFF;

  localparam logic [CfgIdxW-1:0] RegStepCount      = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPressThreshold = 1'd1;

  typedef enum logic [1:0] {
    EvUp    = 2'd0,
    EvDown  = 2'd1,
    EvEnter = 2'd2
  } event_e;

  // one sample's worth of work for the back end
  typedef struct packed {
    logic             up;
    logic [StepW-1:0] rot_cnt;
    logic             enter;
  } cmd_t;

endpackage

// File: rtl/rekeys_front.sv
// ----------------------------------------------------------------------------
// rekeys_front
// Takes scan samples, tracks phase A edge and key debounce, and issues one
// command per sample that causes events. Holds the configuration registers.
// ----------------------------------------------------------------------------
module rekeys_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rekeys_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rekeys_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          phase_a_i,
  input  logic                          phase_b_i,
  input  logic                          key_level_i,
  output logic                          push_o,
  output rekeys_pkg::cmd_t              cmd_o,
  input  logic                          full_i
);
  import rekeys_pkg::*;

  logic [StepW-1:0]   step_q;
  logic [ThreshW-1:0] thresh_q;
  logic               prev_a_q;
  logic [ThreshW-1:0] low_cnt_q, low_cnt_d;
  logic               latched_q, latched_d;
  logic [StepW-1:0]   step_wr;
  logic               accept;
  logic               rise;
  logic               enter;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign rise       = phase_a_i & ~prev_a_q;

  always_comb begin
    step_wr = cfg_wdata_i[StepW-1:0];
    if (step_wr > MaxStep) begin
      step_wr = MaxStep;
    end
  end

  always_comb begin
    low_cnt_d = low_cnt_q;
    latched_d = latched_q;
    enter     = 1'b0;
    if (!key_level_i) begin
      if (low_cnt_q < KeyCountMax) begin
        low_cnt_d = low_cnt_q + 8'd1;
      end
      if ((low_cnt_d >= thresh_q) && !latched_q) begin
        latched_d = 1'b1;
        enter     = 1'b1;
      end
    end else begin
      low_cnt_d = '0;
      latched_d = 1'b0;
    end
  end

  assign cmd_o.up      = phase_b_i;
  assign cmd_o.rot_cnt = rise ? step_q : '0;
  assign cmd_o.enter   = enter;
  assign push_o        = accept & (rise | enter);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StepReset;
      thresh_q  <= ThreshReset;
      prev_a_q  <= 1'b0;
      low_cnt_q <= '0;
      latched_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegStepCount) begin
          if (cfg_wdata_i[StepW-1:0] != '0) begin
            step_q <= step_wr;
          end
        end else if (cfg_index_i == RegPressThreshold) begin
          thresh_q <= cfg_wdata_i[ThreshW-1:0];
        end
      end
      if (accept) begin
        prev_a_q  <= phase_a_i;
        low_cnt_q <= low_cnt_d;
        latched_q <= latched_d;
      end
    end
  end

endmodule

// File: rtl/rekeys_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rekeys_cmd_fifo
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module rekeys_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rekeys_pkg::cmd_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rekeys_pkg::cmd_t head_o
);
  import rekeys_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~cnt_q[1];
  assign do_pop  = pop_i & (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/rekeys_back.sv
// ----------------------------------------------------------------------------
// rekeys_back
// Expands queued commands into events in an output register, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module rekeys_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  rekeys_pkg::cmd_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       event_code_o,
  output logic             last_event_o
);
  import rekeys_pkg::*;

  logic [StepW-1:0] idx_q, idx_d;
  logic             valid_q;
  event_e           code_q, code_d;
  logic             last_q, last_d;
  logic             emit;
  logic             rot;

  assign emit = ~empty_i & (~valid_q | out_ready_i);
  assign rot  = idx_q < head_i.rot_cnt;

  always_comb begin
    idx_d  = idx_q;
    code_d = EvEnter;
    last_d = 1'b1;
    pop_o  = 1'b0;
    if (rot) begin
      code_d = head_i.up ? EvUp : EvDown;
      last_d = ((idx_q + 6'd1) == head_i.rot_cnt) & ~head_i.enter;
    end
    if (emit) begin
      pop_o = last_d;
      idx_d = last_d ? '0 : idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      code_q  <= EvUp;
      last_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (emit) begin
        valid_q <= 1'b1;
        code_q  <= code_d;
        last_q  <= last_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign event_code_o = code_q;
  assign last_event_o = last_q;

endmodule

// File: rtl/rotary_encoder_key_scanner_core.sv
// ----------------------------------------------------------------------------
// rotary_encoder_key_scanner_core
// Quadrature encoder and debounced push-key scanner.
// ----------------------------------------------------------------------------
// Each accepted sample is classified combinationally; a sample that causes
// events is queued as one command; the back end emits its events through the
// output register at one per cycle while the output is not stalled, so a sample
// gives at most step_count + 1 events (rotation events, then the enter event).
// The input side keeps taking samples while the two-entry queue has room.
module rotary_encoder_key_scanner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rekeys_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rekeys_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          phase_a_i,
  input  logic                          phase_b_i,
  input  logic                          key_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    event_code_o,
  output logic                          last_event_o
);
  import rekeys_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic empty;
  cmd_t head;

  rekeys_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .phase_a_i,
    .phase_b_i,
    .key_level_i,
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  rekeys_cmd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  rekeys_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .event_code_o,
    .last_event_o
  );

endmodule

// File: verif/rekeys_checker.sv
// ----------------------------------------------------------------------------
// rekeys_checker
// Scoreboard for the rotary encoder and key scanner core.
// ----------------------------------------------------------------------------
// Watches the register port and both item channels. Every accepted scan
// sample is run through a local model of the encoder edge detector and the
// key debouncer, and the events it causes are queued. Each accepted event is
// checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module rekeys_checker
  import rekeys_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                phase_a_i,
  input  logic                phase_b_i,
  input  logic                key_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          event_code_i,
  input  logic                last_event_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    event_e code;
    logic   is_last;
  } key_event_t;

  key_event_t         event_q[$];
  logic               prev_a;
  logic [ThreshW-1:0] low_cnt;
  logic               press_held;
  logic [StepW-1:0]   step_cnt;
  logic [ThreshW-1:0] press_thresh;
  int unsigned        n_fail;
  int unsigned        n_seen;

  task automatic scan_sample(input logic a, input logic b, input logic key);
    int unsigned n_rot;
    int unsigned n_total;
    logic        enter;
    event_e      rot_code;
    key_event_t  ev;
    n_rot = 0;
    enter = 1'b0;
    rot_code = b ? EvUp : EvDown;
    if (a && !prev_a) begin
      n_rot = step_cnt;
    end
    prev_a = a;
    if (!key) begin
      if (low_cnt != KeyCountMax) begin
        low_cnt = low_cnt + 1'b1;
      end
      if (low_cnt >= press_thresh && !press_held) begin
        press_held = 1'b1;
        enter = 1'b1;
      end
    end else begin
      low_cnt = '0;
      press_held = 1'b0;
    end
    n_total = n_rot + enter;
    for (int unsigned k = 0; k < n_total; k++) begin
      ev.code = (k < n_rot) ? rot_code : EvEnter;
      ev.is_last = (k == n_total - 1);
      event_q.push_back(ev);
    end
  endtask

  task automatic check_event();
    key_event_t ev;
    if (event_q.size() == 0) begin
      n_fail++;
      if (n_fail <= ReportMax) begin
        $display("%0t: unexpected event %0d: code %0d last %0d", $realtime, n_seen,
                 event_code_i, last_event_i);
      end
    end else begin
      ev = event_q.pop_front();
      if (ev.code !== event_code_i || ev.is_last !== last_event_i) begin
        n_fail++;
        if (n_fail <= ReportMax) begin
          $display("%0t: event %0d: expected code %0d last %0d, got code %0d last %0d",
                   $realtime, n_seen, ev.code, ev.is_last, event_code_i, last_event_i);
        end
      end
    end
    n_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q.delete();
      prev_a = 1'b0;
      low_cnt = '0;
      press_held = 1'b0;
      step_cnt = StepReset;
      press_thresh = ThreshReset;
      n_fail = 0;
      n_seen = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_event();
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegStepCount: begin
            if (cfg_wdata_i[StepW-1:0] != '0) begin
              step_cnt = (cfg_wdata_i[StepW-1:0] > MaxStep) ? MaxStep
                                                              : cfg_wdata_i[StepW-1:0];
            end
          end
          RegPressThreshold: begin
            press_thresh = cfg_wdata_i[ThreshW-1:0];
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        scan_sample(phase_a_i, phase_b_i, key_level_i);
      end
      fail_count_o <= n_fail;
      pending_o <= event_q.size();
    end
  end

endmodule

// File: verif/tb_rotary_encoder_key_scanner_core.sv
// ----------------------------------------------------------------------------
// tb_rotary_encoder_key_scanner_core
// Testbench of the rotary encoder and key scanner core.
// ----------------------------------------------------------------------------
// A directed run covers up and down detents, held and falling phase A, the
// debounced press with rotation and enter in one sample, the held press, the
// ignored zero step count, a zero threshold and the register extremes. Random
// phases follow under several register settings, with quadrature-like phase
// streams, key presses around the threshold, one press long enough to
// saturate the counter, random idling on both channels and one long output
// stall. Checking is done by rekeys_checker.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_key_scanner_core;

  timeunit 1ns;
  timeprecision 1ps;

  import rekeys_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               phase_a_i;
  logic               phase_b_i;
  logic               key_level_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         event_code_o;
  logic               last_event_o;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        idle_cycles;

  logic               rx_tight;
  logic               hold_go;
  logic               hold_done;

  logic               enc_a;
  logic               enc_b;
  logic               key_lvl;
  int unsigned        key_left;

  always #4 clk_i = ~clk_i;

  rotary_encoder_key_scanner_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .phase_a_i    (phase_a_i),
    .phase_b_i    (phase_b_i),
    .key_level_i  (key_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .last_event_o (last_event_o)
  );

  rekeys_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .phase_a_i    (phase_a_i),
    .phase_b_i    (phase_b_i),
    .key_level_i  (key_level_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_i (event_code_o),
    .last_event_i (last_event_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // event receiver
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_tight) begin
        out_ready_i <= 1'b1;
      end else begin
        gap = idle_len();
        if (gap == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_sample(input logic a, input logic b, input logic key,
                             input logic tight = 1'b0);
    int unsigned gap;
    in_valid_i <= 1'b1;
    phase_a_i <= a;
    phase_b_i <= b;
    key_level_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = tight ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // both registers, written only once all events are out and the core is quiet
  task automatic write_cfg(input logic [CfgW-1:0] step_data,
                           input logic [CfgW-1:0] thresh_data);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegStepCount;
    cfg_wdata_i <= step_data;
    @(posedge clk_i);
    cfg_index_i <= RegPressThreshold;
    cfg_wdata_i <= thresh_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CfgW-1:0] step_data, input logic [CfgW-1:0] thresh_data,
                           input int unsigned n_items, input logic tight,
                           input int unsigned long_press);
    int unsigned thr;
    int unsigned r;
    write_cfg(step_data, thresh_data);
    rx_tight <= tight;
    thr = (thresh_data == 0) ? 1 : thresh_data;
    key_lvl = 1'b1;
    key_left = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (key_left == 0) begin
        key_lvl = ~key_lvl;
        if (key_lvl) begin
          key_left = $urandom_range(1, 8);
        end else if (long_press != 0) begin
          key_left = long_press;
          long_press = 0;
        end else if ($urandom_range(0, 9) < 7) begin
          key_left = $urandom_range(1, (thr <= 16) ? thr + 3 : 20);
        end else begin
          key_left = $urandom_range(1, 12);
        end
      end
      key_left--;
      r = $urandom_range(0, 9);
      if (r < 4) begin
        enc_a = ~enc_a;
      end else if (r < 7) begin
        enc_b = ~enc_b;
      end else if (r == 7) begin
        enc_a = $urandom_range(0, 1);
        enc_b = $urandom_range(0, 1);
      end
      send_sample(enc_a, enc_b, key_lvl, tight);
    end
    rx_tight <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= RegStepCount;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    phase_a_i <= 1'b0;
    phase_b_i <= 1'b0;
    key_level_i <= 1'b1;
    rx_tight <= 1'b0;
    hold_go <= 1'b0;
    enc_a = 1'b0;
    enc_b = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one event per detent, press after ten low samples
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    // zero step count is dropped, zero threshold acts as one
    write_cfg(8'h40, 8'h00);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0);
    write_cfg(8'hFF, 8'hFF);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);
    write_cfg(8'hC1, 8'h01);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);

    run_phase(8'h03, 8'h04, 30, 1'b0, 0);
    hold_go <= 1'b1;
    run_phase(8'hBF, 8'hFF, 280, 1'b0, 270);
    run_phase(8'h02, 8'h00, 30, 1'b1, 0);
    run_phase(8'h81, 8'h02, 20, 1'b0, 0);
    run_phase(8'h1F, 8'h07, 20, 1'b0, 0);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
